>>> hdl/lchc_pkg.sv
// Package for the LRU cache hit-cost unit: default sizes, cost constants
// and the command and chain structs shared by the top level and its cells.
// No dependencies.
`timescale 1ns / 1ps

package lchc_pkg;

	localparam int LCHC_ENTRIES  = 16;
	localparam int LCHC_KEY_BITS = 64;

	localparam int KEY_W    = 64;
	localparam int SIZE_W   = 5;
	localparam int COST_W   = 32;
	localparam int IN_TDATA_W  = 72;
	localparam int OUT_TDATA_W = 40;

	localparam logic [COST_W-1:0] HIT_COST  = 32'd1;
	localparam logic [COST_W-1:0] MISS_COST = 32'd5;
	localparam logic [COST_W-1:0] COST_MAX  = 32'hFFFF_FFFF;

	// Broadcast to every cell of the row.
	typedef struct packed {
		logic clear;   // empty the cell (start of a new run)
		logic upd;     // apply the lookup outcome this cycle
		logic hit;     // the key was found somewhere in the row
		logic insert;  // a miss that stores the key
		logic evict;   // the oldest entry makes room first
	} cell_cmd_t;

	// Handed from one cell to the next along the row.
	typedef struct packed {
		logic found;   // an earlier cell already matched the key
		logic free;    // an earlier cell already offers a free slot
	} cell_chain_t;

endpackage

>>> hdl/lchc_cell.sv
// One entry of the fully associative cache: tag, valid flag and recency rank.
// Depends on lchc_pkg for the command and chain structs.
`timescale 1ns / 1ps

module lchc_cell
	import lchc_pkg::*;
#(
	parameter int KEY_BITS = LCHC_KEY_BITS,
	parameter int AGE_W    = 4
) (
	input  logic                clk,
	input  logic                arst_n,
	input  cell_cmd_t           cmd,
	input  logic [KEY_BITS-1:0] key,
	input  logic [AGE_W-1:0]    hit_age,
	input  logic [AGE_W-1:0]    oldest_age,
	input  cell_chain_t         chain_in,
	input  logic [AGE_W-1:0]    age_in,
	output cell_chain_t         chain_out,
	output logic [AGE_W-1:0]    age_out
);

	logic                valid_q;
	logic [KEY_BITS-1:0] tag_q;
	logic [AGE_W-1:0]    age_q;

	logic match;
	logic found_here;
	logic victim;
	logic slot_here;
	logic is_free;

	always_comb begin
		match      = valid_q && (tag_q == key);
		found_here = match && !chain_in.found;
		victim     = cmd.evict && valid_q && (age_q == oldest_age);
		// A cell whose entry is being evicted counts as free for the new key.
		is_free    = !valid_q || victim;
		slot_here  = is_free && !chain_in.free;

		chain_out.found = chain_in.found || match;
		chain_out.free  = chain_in.free || is_free;
		age_out         = found_here ? age_q : age_in;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			age_q   <= '0;
		end else if (cmd.clear) begin
			valid_q <= 1'b0;
			age_q   <= '0;
		end else if (cmd.upd) begin
			if (cmd.hit) begin
				if (found_here) begin
					age_q <= '0;
				end else if (valid_q && (age_q < hit_age)) begin
					age_q <= age_q + 1'b1;
				end
			end else if (cmd.insert) begin
				if (slot_here) begin
					valid_q <= 1'b1;
					age_q   <= '0;
				end else if (victim) begin
					valid_q <= 1'b0;
				end else if (valid_q) begin
					age_q <= age_q + 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.upd && !cmd.hit && cmd.insert && slot_here) begin
			tag_q <= key;
		end
	end

endmodule

>>> hdl/lru_cache_hit_cost_unit.sv
// An accepted word goes to the key register; its result word is then written to the output
// register, which waits while the output is stalled. No new word is taken until that result is
// registered. The tag compare and the found and free-slot chains run combinationally through
// the row of cells. Reset clears all cells, the occupancy count, the cost total, the size
// register (zero) and the output valid flag. Depends on lchc_pkg and lchc_cell.
`timescale 1ns / 1ps

module lru_cache_hit_cost_unit
	import lchc_pkg::*;
#(
	parameter int ENTRIES  = LCHC_ENTRIES,
	parameter int KEY_BITS = LCHC_KEY_BITS
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_we,
	input  logic [SIZE_W-1:0]      cfg_wdata,     // cache_size
	input  logic                   s_axis_tvalid,
	output logic                   s_axis_tready,
	input  logic [IN_TDATA_W-1:0]  s_axis_tdata,  // key[63:0], start_req, zero pad
	output logic                   m_axis_tvalid,
	input  logic                   m_axis_tready,
	output logic [OUT_TDATA_W-1:0] m_axis_tdata   // hit, evicted, total_cost[31:0], pad
);

	localparam int AGE_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int CNT_W = $clog2(ENTRIES + 1);

	typedef enum logic [1:0] {
		ST_IDLE = 2'b01,
		ST_WORK = 2'b10
	} state_t;

	state_t              state_q;
	logic [SIZE_W-1:0]   size_q;
	logic [KEY_BITS-1:0] key_q;
	logic [CNT_W-1:0]    count_q;
	logic [COST_W-1:0]   cost_q;
	logic                out_valid_q;
	logic                out_hit_q;
	logic                out_evict_q;
	logic [COST_W-1:0]   out_cost_q;

	logic              accept;
	logic              upd;
	logic              start_in;
	logic [CNT_W-1:0]  limit;
	logic              hit;
	logic              insert;
	logic              evict;
	logic [AGE_W-1:0]  hit_age;
	logic [AGE_W-1:0]  oldest_age;
	logic [COST_W-1:0] add;
	logic [COST_W:0]   cost_sum;
	logic [COST_W-1:0] cost_next;
	cell_cmd_t         cmd;

	cell_chain_t      chain_c [ENTRIES+1];
	logic [AGE_W-1:0] age_c   [ENTRIES+1];

	assign s_axis_tready = (state_q == ST_IDLE);
	assign accept        = s_axis_tvalid && s_axis_tready;
	assign start_in      = s_axis_tdata[KEY_W];
	assign upd           = (state_q == ST_WORK) && (!out_valid_q || m_axis_tready);

	always_comb begin
		if (int'(size_q) > ENTRIES) begin
			limit = CNT_W'(ENTRIES);
		end else begin
			limit = CNT_W'(size_q);
		end
		hit     = chain_c[ENTRIES].found;
		hit_age = age_c[ENTRIES];
		insert  = !hit && (limit != '0);
		evict   = insert && (count_q >= limit);
		// Valid entries hold the distinct ranks 0..count-1, so the oldest is count-1.
		oldest_age = AGE_W'(count_q - 1'b1);

		cmd.clear  = accept && start_in;
		cmd.upd    = upd;
		cmd.hit    = hit;
		cmd.insert = insert;
		cmd.evict  = evict;

		add       = hit ? HIT_COST : MISS_COST;
		cost_sum  = {1'b0, cost_q} + {1'b0, add};
		cost_next = cost_sum[COST_W] ? COST_MAX : cost_sum[COST_W-1:0];
	end

	assign chain_c[0] = '{found: 1'b0, free: 1'b0};
	assign age_c[0]   = '0;

	for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
		lchc_cell #(
			.KEY_BITS (KEY_BITS),
			.AGE_W    (AGE_W)
		) u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.cmd        (cmd),
			.key        (key_q),
			.hit_age    (hit_age),
			.oldest_age (oldest_age),
			.chain_in   (chain_c[i]),
			.age_in     (age_c[i]),
			.chain_out  (chain_c[i+1]),
			.age_out    (age_c[i+1])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			size_q      <= '0;
			count_q     <= '0;
			cost_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				size_q <= cfg_wdata;
			end
			if (upd) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q <= ST_WORK;
						if (start_in) begin
							count_q <= '0;
							cost_q  <= '0;
						end
					end
				end
				ST_WORK: begin
					if (upd) begin
						state_q <= ST_IDLE;
						cost_q  <= cost_next;
						if (insert && !evict) begin
							count_q <= count_q + 1'b1;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			key_q <= s_axis_tdata[KEY_BITS-1:0];
		end
		if (upd) begin
			out_hit_q   <= hit;
			out_evict_q <= evict;
			out_cost_q  <= cost_next;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {{(OUT_TDATA_W - COST_W - 2){1'b0}}, out_cost_q, out_evict_q,
		out_hit_q};

endmodule

>>> verif/tb_lru_cache_hit_cost_unit.sv
// Self-checking testbench for lru_cache_hit_cost_unit: a directed table of lookups and then
// random lookup runs drawn from a small key pool over several cache sizes.
// Depends on lchc_pkg and the RTL of the unit; results are checked against a built-in LRU model.
`timescale 1ns / 1ps

module tb_lru_cache_hit_cost_unit;
	import lchc_pkg::*;

	localparam int NO_RESIZE    = -1;
	localparam int PROBE_ROWS   = 20;
	localparam int PHASES       = 9;
	localparam int PHASE_WORDS  = 150;
	localparam int POOL_DEPTH   = 24;
	localparam int CYCLE_LIMIT  = 200000;
	localparam int DRAIN_CYCLES = 6;

	typedef struct packed {
		logic              hit;
		logic              evicted;
		logic [COST_W-1:0] cost;
	} lookup_t;

	// One row of the directed table. Where known is set, the expected word is typed in.
	typedef struct packed {
		int                new_size;
		logic [KEY_W-1:0]  key;
		logic              start;
		logic              known;
		logic              hit;
		logic              evicted;
		logic [COST_W-1:0] cost;
	} probe_row_t;

	localparam logic [KEY_W-1:0] ALL_ONES = {KEY_W{1'b1}};

	probe_row_t probe_table [PROBE_ROWS] = '{
		'{NO_RESIZE, 64'd0,      1'b0, 1'b1, 1'b0, 1'b0, 32'd5},
		'{NO_RESIZE, ALL_ONES,   1'b0, 1'b1, 1'b0, 1'b0, 32'd10},
		'{NO_RESIZE, 64'd0,      1'b0, 1'b1, 1'b0, 1'b0, 32'd15},
		'{1,         64'd0,      1'b1, 1'b1, 1'b0, 1'b0, 32'd5},
		'{NO_RESIZE, 64'd0,      1'b0, 1'b1, 1'b1, 1'b0, 32'd6},
		'{NO_RESIZE, ALL_ONES,   1'b0, 1'b1, 1'b0, 1'b1, 32'd11},
		'{NO_RESIZE, 64'd0,      1'b0, 1'b1, 1'b0, 1'b1, 32'd16},
		'{31,        64'd0,      1'b1, 1'b1, 1'b0, 1'b0, 32'd5},
		'{NO_RESIZE, 64'd1,      1'b0, 1'b0, 1'b0, 1'b0, 32'd0},
		'{NO_RESIZE, 64'd2,      1'b0, 1'b0, 1'b0, 1'b0, 32'd0},
		'{NO_RESIZE, 64'h8000_0000_0000_0000, 1'b0, 1'b0, 1'b0, 1'b0, 32'd0},
		'{NO_RESIZE, 64'd1,      1'b0, 1'b0, 1'b0, 1'b0, 32'd0},
		'{NO_RESIZE, 64'hFFFF_FFFF_FFFF_FFFE, 1'b0, 1'b0, 1'b0, 1'b0, 32'd0},
		'{0,         64'd2,      1'b0, 1'b0, 1'b0, 1'b0, 32'd0},
		'{NO_RESIZE, 64'd99,     1'b0, 1'b0, 1'b0, 1'b0, 32'd0},
		'{2,         64'h1234_5678_9ABC_DEF0, 1'b0, 1'b0, 1'b0, 1'b0, 32'd0},
		'{NO_RESIZE, 64'd1,      1'b0, 1'b0, 1'b0, 1'b0, 32'd0},
		'{16,        ALL_ONES,   1'b1, 1'b1, 1'b0, 1'b0, 32'd5},
		'{NO_RESIZE, ALL_ONES,   1'b0, 1'b1, 1'b1, 1'b0, 32'd6},
		'{NO_RESIZE, 64'h5555_AAAA_5555_AAAA, 1'b0, 1'b0, 1'b0, 1'b0, 32'd0}
	};

	logic                   clk;
	logic                   arst_n;
	logic                   cfg_we;
	logic [SIZE_W-1:0]      cfg_wdata;
	logic                   s_axis_tvalid;
	logic                   s_axis_tready;
	logic [IN_TDATA_W-1:0]  s_axis_tdata;   // key[63:0], start_req, zero pad
	logic                   m_axis_tvalid;
	logic                   m_axis_tready = 1'b0;
	logic [OUT_TDATA_W-1:0] m_axis_tdata;   // hit, evicted, total_cost[31:0], pad

	// Model of the cache contents, the size register and the running cost.
	logic [KEY_W-1:0]  cache_tag   [LCHC_ENTRIES];
	logic              cache_valid [LCHC_ENTRIES];
	logic [4:0]        cache_rank  [LCHC_ENTRIES];
	logic [COST_W-1:0] cost_sum;
	logic [SIZE_W-1:0] size_reg;

	lookup_t          pending_results [$];
	logic [KEY_W-1:0] key_pool [POOL_DEPTH];
	int               send_idle_pct;
	int               recv_idle_pct;
	int               mismatch_count;
	int               words_checked;
	int               cycle_count;

	lru_cache_hit_cost_unit dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_wdata     (cfg_wdata),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("simulation failed");
		$finish;
	end

	always @(posedge clk) begin
		m_axis_tready <= ($urandom_range(99, 0) >= recv_idle_pct);
	end

	function automatic logic [COST_W-1:0] saturating_add(logic [COST_W-1:0] total,
			logic [COST_W-1:0] step);
		return (total > COST_MAX - step) ? COST_MAX : total + step;
	endfunction

	// Applies one lookup to the model and returns the word the unit should produce.
	task automatic lru_lookup(input logic [KEY_W-1:0] key, input logic start,
			output lookup_t res);
		int         limit;
		int         count;
		int         found;
		int         oldest;
		int         slot;
		logic [4:0] rank;
		limit = (size_reg > LCHC_ENTRIES) ? LCHC_ENTRIES : int'(size_reg);
		count = 0;
		found = -1;
		oldest = -1;
		slot = -1;
		res = '0;
		if (start) begin
			for (int i = 0; i < LCHC_ENTRIES; i++) begin
				cache_valid[i] = 1'b0;
				cache_rank[i] = '0;
			end
			cost_sum = '0;
		end
		for (int i = 0; i < LCHC_ENTRIES; i++) begin
			if (cache_valid[i]) begin
				count++;
				if (found < 0 && cache_tag[i] == key)
					found = i;
			end
		end
		if (found >= 0) begin
			// Only entries more recent than the one hit move back a place.
			rank = cache_rank[found];
			res.hit = 1'b1;
			cost_sum = saturating_add(cost_sum, HIT_COST);
			for (int i = 0; i < LCHC_ENTRIES; i++)
				if (cache_valid[i] && cache_rank[i] < rank)
					cache_rank[i]++;
			cache_rank[found] = '0;
		end else begin
			cost_sum = saturating_add(cost_sum, MISS_COST);
			if (limit != 0) begin
				// A lowered size still evicts just the single oldest entry.
				if (count >= limit) begin
					for (int i = 0; i < LCHC_ENTRIES; i++)
						if (cache_valid[i] && (oldest < 0 || cache_rank[i] > cache_rank[oldest]))
							oldest = i;
					if (oldest >= 0) begin
						rank = cache_rank[oldest];
						cache_valid[oldest] = 1'b0;
						res.evicted = 1'b1;
						for (int i = 0; i < LCHC_ENTRIES; i++)
							if (cache_valid[i] && cache_rank[i] > rank)
								cache_rank[i]--;
					end
				end
				for (int i = LCHC_ENTRIES - 1; i >= 0; i--)
					if (!cache_valid[i])
						slot = i;
				if (slot >= 0) begin
					for (int i = 0; i < LCHC_ENTRIES; i++)
						if (cache_valid[i])
							cache_rank[i]++;
					cache_valid[slot] = 1'b1;
					cache_tag[slot] = key;
					cache_rank[slot] = '0;
				end
			end
		end
		res.cost = cost_sum;
	endtask

	task automatic report_mismatch(input string field, input logic [COST_W-1:0] got,
			input logic [COST_W-1:0] want);
		if (mismatch_count < 40)
			$display("mismatch on result word %0d: %s is %0h, %0h expected",
				words_checked, field, got, want);
		mismatch_count++;
	endtask

	// Compares every accepted result word with the oldest expectation.
	always @(posedge clk) begin
		lookup_t want;
		if (m_axis_tvalid && m_axis_tready) begin
			if (pending_results.size() == 0) begin
				report_mismatch("unexpected word", m_axis_tdata[COST_W+1:2], '0);
			end else begin
				want = pending_results.pop_front();
				if (m_axis_tdata[0] !== want.hit)
					report_mismatch("hit", COST_W'(m_axis_tdata[0]), COST_W'(want.hit));
				if (m_axis_tdata[1] !== want.evicted)
					report_mismatch("evicted", COST_W'(m_axis_tdata[1]),
						COST_W'(want.evicted));
				if (m_axis_tdata[COST_W+1:2] !== want.cost)
					report_mismatch("total_cost", m_axis_tdata[COST_W+1:2], want.cost);
			end
			words_checked++;
		end
	end

	// Offers one lookup word, with random gaps before it, and waits for its acceptance.
	task automatic send_lookup(input logic [KEY_W-1:0] key, input logic start,
			input logic known, input lookup_t typed);
		lookup_t res;
		while ($urandom_range(99, 0) < send_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {{(IN_TDATA_W - KEY_W - 1){1'b0}}, start, key};
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		lru_lookup(key, start, res);
		pending_results.push_back(known ? typed : res);
	endtask

	// The size register is only written once the unit has nothing in flight.
	task automatic write_size(input logic [SIZE_W-1:0] value);
		s_axis_tvalid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we    <= 1'b0;
		size_reg = value;
	endtask

	function automatic logic [KEY_W-1:0] random_key();
		return {$urandom(), $urandom()};
	endfunction

	initial begin
		lookup_t          typed;
		logic [KEY_W-1:0] key;
		int               size_pick;
		int               limit;
		int               span;
		cfg_we        = 1'b0;
		cfg_wdata     = '0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata  = '0;
		arst_n        = 1'b0;
		send_idle_pct = 10;
		recv_idle_pct = 47;
		size_reg      = '0;
		cost_sum      = '0;
		for (int i = 0; i < LCHC_ENTRIES; i++) begin
			cache_tag[i]   = '0;
			cache_valid[i] = 1'b0;
			cache_rank[i]  = '0;
		end
		for (int i = 0; i < POOL_DEPTH; i++)
			key_pool[i] = random_key();
		key_pool[0] = '0;
		key_pool[1] = ALL_ONES;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (probe_table[r]) begin
			if (probe_table[r].new_size != NO_RESIZE)
				write_size(probe_table[r].new_size[SIZE_W-1:0]);
			typed.hit     = probe_table[r].hit;
			typed.evicted = probe_table[r].evicted;
			typed.cost    = probe_table[r].cost;
			send_lookup(probe_table[r].key, probe_table[r].start, probe_table[r].known, typed);
		end

		// Three idling modes, three sizes each; extremes and a lowered size among them.
		for (int phase = 0; phase < PHASES; phase++) begin
			case (phase % 9)
				0: size_pick = 16;
				1: size_pick = 1;
				2: size_pick = 0;
				3: size_pick = 31;
				4: size_pick = $urandom_range(15, 2);
				5: size_pick = 16;
				6: size_pick = $urandom_range(30, 17);
				7: size_pick = 0;
				default: size_pick = $urandom_range(4, 2);
			endcase
			write_size(size_pick[SIZE_W-1:0]);
			send_idle_pct = (phase / 3 == 0) ? 10 : (phase / 3 == 1) ? 47 : 0;
			recv_idle_pct = (phase / 3 == 0) ? 47 : (phase / 3 == 1) ? 10 : 0;
			for (int i = 0; i < 4; i++)
				key_pool[$urandom_range(POOL_DEPTH - 1, 2)] = random_key();
			limit = (size_pick > LCHC_ENTRIES) ? LCHC_ENTRIES : size_pick;
			// With size zero only entries left from earlier phases can hit.
			span = (limit == 0) ? 20 : (limit + 4 > POOL_DEPTH) ? POOL_DEPTH : limit + 4;
			for (int n = 0; n < PHASE_WORDS; n++) begin
				if ($urandom_range(99, 0) < 85)
					key = key_pool[$urandom_range(span - 1, 0)];
				else
					key = random_key();
				send_lookup(key, $urandom_range(99, 0) == 0, 1'b0, '0);
			end
		end

		s_axis_tvalid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatch_count == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
